>>> rtl/core/lane_marking_deviation_scan_unit_macros.svh
// assertion helpers for the lane marking deviation scan
`ifndef LANE_MARKING_DEVIATION_SCAN_UNIT_MACROS_SVH
`define LANE_MARKING_DEVIATION_SCAN_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define LMDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LMDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lmds_pkg.sv
package lmds_pkg;

    // field and register widths
    localparam int PIX_W   = 8;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 10;
    localparam int DIM_W   = 11;
    localparam int OFF_W   = 10;
    localparam int Q_W     = 16;
    localparam int SPD_W   = 2;

    // deviation arithmetic
    localparam int NUM_W   = 14;
    localparam int MAG_W   = 12;
    localparam int FRAC_SH = 11;
    localparam int DVD_W   = MAG_W + FRAC_SH;
    localparam int DVS_W   = OFF_W;
    localparam int CNT_W   = $clog2(DVD_W);

    // divide by ten through a reciprocal, exact for values below 2048
    localparam int RECIP_10 = 3277;
    localparam int RECIP_SH = 15;
    localparam int PROD_W   = DIM_W + 12;
    localparam int QT_W     = PROD_W - RECIP_SH;

    // sampled rows start this far above the bottom
    localparam int ROW_MARGIN = 8;

    // control strobes from the sequencer to the find tracker
    typedef struct packed {
        logic upd;
        logic bright;
        logic row_end;
        logic at_ctrl;
        logic below_ctrl;
        logic clear;
    } t_scan_ctl;

    // finds kept for the frame-end evaluation
    typedef struct packed {
        logic [COL_W-1:0] ctrl_left;
        logic [COL_W-1:0] ctrl_right;
        logic [COL_W-1:0] below_left;
        logic [COL_W-1:0] below_right;
        logic             ctrl_seen;
    } t_finds;

endpackage

>>> rtl/core/lmds_scan.sv
module lmds_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lmds_pkg::t_scan_ctl       i_ctl,
    input  logic [lmds_pkg::COL_W-1:0] i_col,
    input  logic [lmds_pkg::COL_W-1:0] i_half,
    output lmds_pkg::t_finds          o_finds
);
    import lmds_pkg::*;

    logic [COL_W-1:0] r_row_left, r_row_right;
    logic [COL_W-1:0] n_row_left, n_row_right;
    t_finds           r_finds, n_finds;

    always_comb begin
        n_row_left  = r_row_left;
        n_row_right = r_row_right;
        n_finds     = r_finds;
        if (i_ctl.upd) begin
            // left keeps the largest column, right the smallest
            if (i_ctl.bright && i_col != '0 && i_col <= i_half && i_col > r_row_left) begin
                n_row_left = i_col;
            end
            if (i_ctl.bright && i_col >= i_half &&
                (r_row_right == '0 || i_col < r_row_right)) begin
                n_row_right = i_col;
            end
            if (i_ctl.row_end) begin
                if (i_ctl.at_ctrl) begin
                    n_finds.ctrl_left  = n_row_left;
                    n_finds.ctrl_right = n_row_right;
                    n_finds.ctrl_seen  = 1'b1;
                end else if (i_ctl.below_ctrl) begin
                    if (r_finds.below_left == '0) begin
                        n_finds.below_left = n_row_left;
                    end
                    if (r_finds.below_right == '0) begin
                        n_finds.below_right = n_row_right;
                    end
                end
                n_row_left  = '0;
                n_row_right = '0;
            end
        end
        if (i_ctl.clear) begin
            n_row_left  = '0;
            n_row_right = '0;
            n_finds     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_left  <= '0;
            r_row_right <= '0;
            r_finds     <= '0;
        end else begin
            r_row_left  <= n_row_left;
            r_row_right <= n_row_right;
            r_finds     <= n_finds;
        end
    end

    assign o_finds = r_finds;

endmodule

>>> rtl/core/lmds_div.sv
module lmds_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lmds_pkg::DVD_W-1:0] i_dividend,
    input  logic [lmds_pkg::DVS_W-1:0] i_divisor,
    output logic [lmds_pkg::DVD_W-1:0] o_quot,
    output logic                       o_done
);
    import lmds_pkg::*;

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem, r_dvs;
    logic [DVD_W-1:0] r_quot;
    logic [DVS_W:0]   rem_sh;
    logic             fits;

    // one quotient bit per cycle, restoring
    assign rem_sh = {r_rem, r_quot[DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DVD_W-2:0], fits};
            r_rem  <= fits ? DVS_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[DVS_W-1:0];
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

>>> rtl/core/lane_marking_deviation_scan_unit.sv
// channel   dir  beat contents
// s_t*      in   one pixel: value, column, row
// m_t*      out  one frame result: deviation, steering, speed code, no-lines flag
// apb       in   five config registers at 4*index
//
// a pixel passes accept, row check and find update in turn; ready drops meanwhile
// the frame's last pixel then runs load, divider start, the 23-step shared divider and emit
// result sits in an output register, so a new frame runs while it waits
// a full output register stalls the next frame end, and the pixel scan with it
// reset is synchronous active low; all finds clear at once, no clearing pass
`include "lane_marking_deviation_scan_unit_macros.svh"

module lane_marking_deviation_scan_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_value[7:0], column[17:8], row_index[27:18], zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // deviation_q12[15:0], steering_q12[31:16],
                                   // speed_code[33:32], zero
    output logic [0:0]  m_tuser,   // lines_missing[0]
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lmds_pkg::*;

    // register map by word index
    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_THRESH = 3'd2,
        REG_CTRL   = 3'd3,
        REG_OFFSET = 3'd4
    } t_reg_idx;

    typedef enum logic [SPD_W-1:0] {
        SPD_NONE     = 2'd0,
        SPD_CURVE    = 2'd1,
        SPD_STRAIGHT = 2'd2
    } t_speed;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHK   = 7'b0000010,
        S_UPD   = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_START = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // ---------------- config registers ----------------
    logic [DIM_W-1:0] r_width, r_height;
    logic [PIX_W-1:0] r_thresh;
    logic [ROW_W-1:0] r_ctrl_row;
    logic [OFF_W-1:0] r_offset;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= DIM_W'(640);
            r_height   <= DIM_W'(480);
            r_thresh   <= PIX_W'(200);
            r_ctrl_row <= ROW_W'(462);
            r_offset   <= OFF_W'(280);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WIDTH:  r_width    <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height   <= pwdata[DIM_W-1:0];
                REG_THRESH: r_thresh   <= pwdata[PIX_W-1:0];
                REG_CTRL:   r_ctrl_row <= pwdata[ROW_W-1:0];
                REG_OFFSET: r_offset   <= pwdata[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            REG_THRESH: prdata = 32'(r_thresh);
            REG_CTRL:   prdata = 32'(r_ctrl_row);
            REG_OFFSET: prdata = 32'(r_offset);
            default:    prdata = '0;
        endcase
    end

    // ---------------- pixel capture ----------------
    logic [PIX_W-1:0] r_pix;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             in_beat;

    assign s_tready = (r_state == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_pix <= s_tdata[7:0];
            r_col <= s_tdata[17:8];
            r_row <= s_tdata[27:18];
        end
    end

    // ---------------- row check, first cycle ----------------
    // a row is sampled when it lies 8 + 10k above the bottom and below 0.6 height
    logic             chk_in_frame, chk_low_ok, chk_upper;
    logic [DIM_W-1:0] chk_diff;
    logic [PROD_W-1:0] chk_prod;
    logic [12:0]      row_x5, height_x3;

    logic             r_in_frame, r_low_ok, r_upper;
    logic [DIM_W-1:0] r_diff;
    logic [QT_W-1:0]  r_q;

    assign chk_in_frame = ({1'b0, r_col} < r_width) && ({1'b0, r_row} < r_height);
    assign chk_low_ok   = ({1'b0, r_row} + DIM_W'(ROW_MARGIN)) <= r_height;
    assign chk_diff     = r_height - DIM_W'(ROW_MARGIN) - {1'b0, r_row};
    assign chk_prod     = PROD_W'(chk_diff) * PROD_W'(RECIP_10);
    assign row_x5       = {1'b0, r_row, 2'b00} + 13'(r_row);
    assign height_x3    = {1'b0, r_height, 1'b0} + 13'(r_height);
    assign chk_upper    = row_x5 > height_x3;

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHK) begin
            r_in_frame <= chk_in_frame;
            r_low_ok   <= chk_low_ok;
            r_upper    <= chk_upper;
            r_diff     <= chk_diff;
            r_q        <= chk_prod[PROD_W-1:RECIP_SH];
        end
    end

    // row check, S_UPD part, and find update
    logic [DIM_W-1:0] upd_rem;
    logic             upd_sampled, upd_row_end, upd_frame_end;
    t_scan_ctl        scan_ctl;
    t_finds           finds;

    // remainder of the row distance by ten
    assign upd_rem       = r_diff - DIM_W'({r_q, 3'b000}) - DIM_W'({r_q, 1'b0});
    assign upd_sampled   = r_in_frame && r_low_ok && r_upper && (upd_rem == '0);
    assign upd_row_end   = ({1'b0, r_col} == (r_width - 1'b1));
    assign upd_frame_end = r_in_frame && upd_row_end && ({1'b0, r_row} == (r_height - 1'b1));

    always_comb begin
        scan_ctl            = '0;
        scan_ctl.upd        = (r_state == S_UPD) && upd_sampled;
        scan_ctl.bright     = r_pix >= r_thresh;
        scan_ctl.row_end    = upd_row_end;
        scan_ctl.at_ctrl    = r_row == r_ctrl_row;
        scan_ctl.below_ctrl = r_row > r_ctrl_row;
        scan_ctl.clear      = (r_state == S_LOAD);
    end

    lmds_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_col   (r_col),
        .i_half  (r_width[DIM_W-1:1]),
        .o_finds (finds)
    );

    // ---------------- frame end: error numerator ----------------
    // right find wins; a side missing at the control row falls back to rows below
    logic [COL_W-1:0]        lx, rx;
    logic [OFF_W-1:0]        d_eff;
    logic signed [NUM_W-1:0] ld_num;
    logic                    ld_missing;

    logic signed [NUM_W-1:0] r_num;
    logic                    r_missing;
    logic [OFF_W-1:0]        r_deff;

    assign lx    = (finds.ctrl_left  != '0) ? finds.ctrl_left  : finds.below_left;
    assign rx    = (finds.ctrl_right != '0) ? finds.ctrl_right : finds.below_right;
    assign d_eff = (r_offset == '0) ? OFF_W'(1) : r_offset;

    always_comb begin
        ld_num     = '0;
        ld_missing = 1'b0;
        if (finds.ctrl_seen) begin
            if (rx != '0) begin
                ld_num = $signed(NUM_W'({rx, 1'b0})) - $signed(NUM_W'(r_width))
                       - $signed(NUM_W'({d_eff, 1'b0}));
            end else if (lx != '0) begin
                ld_num = $signed(NUM_W'({lx, 1'b0})) - $signed(NUM_W'(r_width))
                       + $signed(NUM_W'({d_eff, 1'b0}));
            end else begin
                ld_missing = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_num     <= ld_num;
            r_missing <= ld_missing;
            r_deff    <= d_eff;
        end
    end

    // ---------------- shared divider: |num| * 2048 / d ----------------
    logic [NUM_W-1:0] num_abs;
    logic [MAG_W-1:0] mag;
    logic [DVD_W-1:0] quot;
    logic             div_done;

    assign num_abs = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign mag     = num_abs[MAG_W-1:0];

    lmds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend ({mag, FRAC_SH'(0)}),
        .i_divisor  (r_deff),
        .o_quot     (quot),
        .o_done     (div_done)
    );

    // ---------------- result shaping ----------------
    logic [Q_W-1:0]  dev_sat;
    logic [17:0]     mag_x50;
    logic            steer_on;
    logic            out_load;
    logic [Q_W-1:0]  res_dev, res_steer;
    t_speed          res_speed;

    // truncation toward zero comes from dividing the magnitude
    always_comb begin
        if (!r_num[NUM_W-1]) begin
            dev_sat = (quot > DVD_W'(32767)) ? 16'h7FFF : quot[Q_W-1:0];
        end else begin
            dev_sat = (quot > DVD_W'(32768)) ? 16'h8000 : Q_W'(-quot[Q_W-1:0]);
        end
    end

    // error above one percent: 50 * |num| > d
    assign mag_x50  = 18'({mag, 5'b0}) + 18'({mag, 4'b0}) + 18'({mag, 1'b0});
    assign steer_on = mag_x50 > 18'(r_deff);

    always_comb begin
        if (r_missing) begin
            res_dev   = '0;
            res_steer = '0;
            res_speed = SPD_NONE;
        end else begin
            res_dev   = dev_sat;
            res_steer = steer_on ? dev_sat : '0;
            res_speed = steer_on ? SPD_CURVE : SPD_STRAIGHT;
        end
    end

    // output register, parts the scan from the result consumer
    logic             r_out_valid;
    logic [Q_W-1:0]   r_out_dev, r_out_steer;
    logic [SPD_W-1:0] r_out_speed;
    logic             r_out_missing;

    assign out_load = (r_state == S_EMIT) && (!r_out_valid || m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_dev     <= res_dev;
            r_out_steer   <= res_steer;
            r_out_speed   <= res_speed;
            r_out_missing <= r_missing;
        end
    end

    assign m_tvalid   = r_out_valid;
    assign m_tdata    = {6'b0, r_out_speed, r_out_steer, r_out_dev};
    assign m_tuser[0] = r_out_missing;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_beat) n_state = S_CHK;
            S_CHK:   n_state = S_UPD;
            S_UPD:   n_state = upd_frame_end ? S_LOAD : S_IDLE;
            S_LOAD:  n_state = S_START;
            S_START: n_state = S_WAIT;
            S_WAIT:  if (div_done) n_state = S_EMIT;
            S_EMIT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- checks ----------------
    `LMDS_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready, "pixel taken while a pixel is in work")
    `LMDS_ASSERT_NOW(a_missing_clean, i_clk, i_rst_n, m_tvalid && m_tuser[0], m_tdata[31:0] == 32'd0 && m_tdata[33:32] == SPD_NONE, "no-lines result carries data")
    `LMDS_ASSERT_NEXT(a_emit_waits, i_clk, i_rst_n, r_state == S_EMIT && r_out_valid && !m_tready, r_state == S_EMIT && r_out_valid, "result dropped on full output")
    `LMDS_ASSERT_NOW(a_div_done_in_wait, i_clk, i_rst_n, div_done, r_state == S_WAIT, "divider finished outside its wait")

endmodule

>>> tb/sv/lane_marking_deviation_scan_unit_test.sv
`timescale 1ns / 1ps

module lane_marking_deviation_scan_unit_test;
    import lmds_pkg::*;

    // register indexes, byte address is 4*index
    localparam int REG_WIDTH     = 0;
    localparam int REG_HEIGHT    = 1;
    localparam int REG_THRESHOLD = 2;
    localparam int REG_CTRL_ROW  = 3;
    localparam int REG_OFFSET    = 4;

    // speed codes carried in the result beat
    localparam logic [SPD_W-1:0] SPEED_NO_LINES = 2'd0;
    localparam logic [SPD_W-1:0] SPEED_CURVE    = 2'd1;
    localparam logic [SPD_W-1:0] SPEED_STRAIGHT = 2'd2;

    // receiver stall patterns
    localparam int RX_ALWAYS = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_SPARSE = 2;

    localparam int FRAME_LIMIT    = 1024;   // pixels beyond this never count
    localparam int ITEM_TARGET    = 1950;
    localparam int RESULT_TARGET  = 48;
    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 800;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [Q_W-1:0]   deviation;
        logic [Q_W-1:0]   steering;
        logic [SPD_W-1:0] speed;
        logic             missing;
    } lane_result_t;

    // clock, reset and block ports
    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // pixel_value[7:0], column[17:8], row_index[27:18], zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // deviation_q12[15:0], steering_q12[31:16], speed_code[33:32]
    logic [0:0]  m_tuser;         // lines_missing[0]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    lane_marking_deviation_scan_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // local copy of the register file, reset values
    int cfg_width     = 640;
    int cfg_height    = 480;
    int cfg_threshold = 200;
    int cfg_ctrl_row  = 462;
    int cfg_offset    = 280;

    // find tracker copy, zero means no find
    int  row_left, row_right;
    int  ctl_left, ctl_right;
    int  low_left, low_right;
    bit  ctl_seen;

    pixel_t       pixel_q[$];          // pixels waiting to be offered
    lane_result_t frame_result_q[$];   // results owed by frames already scanned

    int pixels_sent;
    int results_seen;
    int mismatch_count;
    int hold_req;
    int hold_ack;

    // rows sampled for marking finds: height-8, height-18, ... below 0.6 of height
    function automatic bit row_is_sampled(input int h, input int r);
        if (r + 8 > h)
            return 1'b0;
        if ((h - 8 - r) % 10 != 0)
            return 1'b0;
        return 5 * r > 3 * h;
    endfunction

    function automatic logic [Q_W-1:0] clamp_q12(input longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[Q_W-1:0];
    endfunction

    // deviation from the committed finds, right side first, falling back to lower rows
    function automatic lane_result_t frame_deviation();
        lane_result_t res;
        longint       w, d, num, q, mag;
        int           lx, rx;
        bit           no_lines;
        w        = cfg_width;
        d        = (cfg_offset == 0) ? 1 : cfg_offset;
        lx       = (ctl_left != 0) ? ctl_left : low_left;
        rx       = (ctl_right != 0) ? ctl_right : low_right;
        num      = 0;
        no_lines = 1'b0;
        res      = '0;
        if (ctl_seen) begin
            if (rx > 0)
                num = 2 * longint'(rx) - w - 2 * d;
            else if (lx > 0)
                num = 2 * longint'(lx) - w + 2 * d;
            else
                no_lines = 1'b1;
        end
        if (no_lines) begin
            res.speed   = SPEED_NO_LINES;
            res.missing = 1'b1;
        end else begin
            // q12 with an extra factor 2 folded into the 2d divisor
            q             = (num * 2048) / d;
            mag           = (num < 0) ? -num : num;
            res.deviation = clamp_q12(q);
            res.speed     = SPEED_STRAIGHT;
            if (50 * mag > d) begin
                res.steering = res.deviation;
                res.speed    = SPEED_CURVE;
            end
        end
        return res;
    endfunction

    // one accepted pixel; returns 1 with the frame result at the frame's last pixel
    function automatic bit scan_pixel(input pixel_t p, output lane_result_t res);
        int col, row, half;
        bit bright;
        col  = p.col;
        row  = p.row;
        half = cfg_width / 2;
        res  = '0;
        if (col >= cfg_width || row >= cfg_height || col >= FRAME_LIMIT || row >= FRAME_LIMIT)
            return 1'b0;
        if (row_is_sampled(cfg_height, row)) begin
            bright = p.value >= cfg_threshold;
            // left keeps the column nearest center, column 0 never counts
            if (bright && col >= 1 && col <= half && col > row_left)
                row_left = col;
            if (bright && col >= half && (row_right == 0 || col < row_right))
                row_right = col;
            // row end commits the row's finds
            if (col == cfg_width - 1) begin
                if (row == cfg_ctrl_row) begin
                    ctl_left  = row_left;
                    ctl_right = row_right;
                    ctl_seen  = 1'b1;
                end else if (row > cfg_ctrl_row) begin
                    if (low_left == 0)
                        low_left = row_left;
                    if (low_right == 0)
                        low_right = row_right;
                end
                row_left  = 0;
                row_right = 0;
            end
        end
        if (row == cfg_height - 1 && col == cfg_width - 1) begin
            res       = frame_deviation();
            row_left  = 0;
            row_right = 0;
            ctl_left  = 0;
            ctl_right = 0;
            low_left  = 0;
            low_right = 0;
            ctl_seen  = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // sender: bursts of random length, random gaps in between
    pixel_t       cur_pixel;
    lane_result_t owed;
    int           burst_left;
    int           gap_left;

    always @(posedge i_clk) begin
        bit busy;
        if (!i_rst_n) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                busy = 1'b0;
                if (scan_pixel(cur_pixel, owed))
                    frame_result_q.push_back(owed);
            end
            if (!busy) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    cur_pixel = pixel_q.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {4'b0, cur_pixel.row, cur_pixel.col, cur_pixel.value};
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(24, 1);
                        case ($urandom_range(7, 0))
                            0, 1, 2: gap_left = 0;
                            3:       gap_left = $urandom_range(20, 8);
                            default: gap_left = $urandom_range(6, 1);
                        endcase
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern changes at random intervals, long hold on request
    int hold_left;
    int mode_left;
    int stall_mode;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            mode_left  <= 0;
            stall_mode <= RX_ALWAYS;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(RX_SPARSE, RX_ALWAYS);
                mode_left  <= $urandom_range(300, 20);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_HALF:   m_tready <= $urandom_range(1, 0);
                default:   m_tready <= ($urandom_range(4, 0) == 0);
            endcase
        end
    end

    // result checker, oldest owed result first
    always @(posedge i_clk) begin
        lane_result_t got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.deviation = m_tdata[15:0];
            got.steering  = m_tdata[31:16];
            got.speed     = m_tdata[33:32];
            got.missing   = m_tuser[0];
            results_seen  = results_seen + 1;
            if (frame_result_q.size() == 0) begin
                $display("%0t: result beat with none owed: dev %0d steer %0d speed %0d missing %0b",
                         $time, $signed(got.deviation), $signed(got.steering), got.speed,
                         got.missing);
                mismatch_count = mismatch_count + 1;
            end else begin
                want = frame_result_q.pop_front();
                if (got.deviation !== want.deviation) begin
                    $display("%0t: deviation expected %0d got %0d", $time,
                             $signed(want.deviation), $signed(got.deviation));
                    mismatch_count = mismatch_count + 1;
                end
                if (got.steering !== want.steering) begin
                    $display("%0t: steering expected %0d got %0d", $time,
                             $signed(want.steering), $signed(got.steering));
                    mismatch_count = mismatch_count + 1;
                end
                if (got.speed !== want.speed) begin
                    $display("%0t: speed code expected %0d got %0d", $time,
                             want.speed, got.speed);
                    mismatch_count = mismatch_count + 1;
                end
                if (got.missing !== want.missing) begin
                    $display("%0t: lines missing expected %0b got %0b", $time,
                             want.missing, got.missing);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // watchdog on cycles where no handshake completes anywhere
    int quiet_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("lane_marking_deviation_scan_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // register write: setup cycle then access cycle
    task automatic apb_write(input int idx, input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:     cfg_width     = value & 'h7FF;
            REG_HEIGHT:    cfg_height    = value & 'h7FF;
            REG_THRESHOLD: cfg_threshold = value & 'hFF;
            REG_CTRL_ROW:  cfg_ctrl_row  = value & 'h3FF;
            REG_OFFSET:    cfg_offset    = value & 'h3FF;
            default: ;
        endcase
    endtask

    task automatic write_config(input int w, input int h, input int thr, input int ctl,
                                input int off);
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        apb_write(REG_THRESHOLD, thr);
        apb_write(REG_CTRL_ROW, ctl);
        apb_write(REG_OFFSET, off);
    endtask

    task automatic push_pixel(input int value, input int col, input int row);
        pixel_t p;
        p.value = value;
        p.col   = col;
        p.row   = row;
        pixel_q.push_back(p);
        if (col < cfg_width && row < cfg_height)
            pixels_sent = pixels_sent + 1;
    endtask

    // values around the threshold, with the extremes now and then
    function automatic int marking_value();
        case ($urandom_range(9, 0))
            0:       return 0;
            1:       return 255;
            2, 3, 4, 5, 6:
                     return $urandom_range(255, cfg_threshold);
            default: return (cfg_threshold == 0) ? 0 : $urandom_range(cfg_threshold - 1, 0);
        endcase
    endfunction

    // one frame: full raster, or only the sampled rows, stray pixels and the frame's last pixel
    task automatic add_frame(input bit raster);
        int n;
        if (raster) begin
            for (int r = 0; r < cfg_height; r++)
                for (int c = 0; c < cfg_width; c++)
                    push_pixel(marking_value(), c, r);
        end else begin
            for (int r = 0; r < cfg_height; r++) begin
                if (row_is_sampled(cfg_height, r)) begin
                    n = $urandom_range(4, 0);
                    repeat (n)
                        push_pixel(marking_value(), $urandom_range(cfg_width - 1, 0), r);
                    // a dropped row end leaves the finds to the next sampled row
                    if ($urandom_range(9, 0) != 0)
                        push_pixel(marking_value(), cfg_width - 1, r);
                end
                // stray pixel anywhere in the address range
                if ($urandom_range(199, 0) == 0)
                    push_pixel($urandom_range(255, 0), $urandom_range(1023, 0),
                               $urandom_range(1023, 0));
            end
            push_pixel(marking_value(), cfg_width - 1, cfg_height - 1);
        end
    endtask

    // all pixels taken, nothing owed, then room for a frame end with no result
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (pixel_q.size() != 0 || s_tvalid || frame_result_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic pick_config();
        int w, h, thr, ctl, off;
        int rows[$];
        case ($urandom_range(5, 0))
            0:       w = 2;
            1:       w = 1024;
            2, 3:    w = $urandom_range(16, 3);
            default: w = $urandom_range(1024, 2);
        endcase
        case ($urandom_range(6, 0))
            0:       h = 2;
            1:       h = $urandom_range(7, 3);
            2, 3, 4: h = $urandom_range(70, 21);
            5:       h = 1024;
            default: h = $urandom_range(1024, 2);
        endcase
        case ($urandom_range(3, 0))
            0:       thr = 0;
            1:       thr = 255;
            default: thr = $urandom_range(255, 0);
        endcase
        for (int r = 0; r < h; r++)
            if (row_is_sampled(h, r))
                rows.push_back(r);
        // mostly a sampled control row, else 0, 1023 or any row index
        if (rows.size() != 0 && $urandom_range(9, 0) < 7) begin
            ctl = rows[$urandom_range(rows.size() - 1, 0)];
        end else begin
            case ($urandom_range(2, 0))
                0:       ctl = 0;
                1:       ctl = 1023;
                default: ctl = $urandom_range(1023, 0);
            endcase
        end
        case ($urandom_range(3, 0))
            0:       off = 1;
            1:       off = 1023;
            2:       off = $urandom_range(20, 1);
            default: off = $urandom_range(1023, 1);
        endcase
        write_config(w, h, thr, ctl, off);
    endtask

    initial begin
        pixels_sent    = 0;
        results_seen   = 0;
        mismatch_count = 0;
        hold_req       = 0;
        hold_ack       = 0;
        quiet_cycles   = 0;
        row_left       = 0;
        row_right      = 0;
        ctl_left       = 0;
        ctl_right      = 0;
        low_left       = 0;
        low_right      = 0;
        ctl_seen       = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames at reset settings: 640x480, control row 462
        // right side wins, right finds arrive far to near, center column counts both sides
        push_pixel(210, 600, 462);
        push_pixel(255, 500, 462);
        push_pixel(200, 330, 462);
        push_pixel(250, 320, 462);
        push_pixel(199, 100, 462);
        push_pixel(255, 1, 462);
        push_pixel(0, 639, 462);
        push_pixel(0, 639, 479);
        // nothing at the control row, right find on the next lower sampled row
        push_pixel(0, 639, 462);
        push_pixel(255, 0, 472);
        push_pixel(255, 400, 472);
        push_pixel(0, 639, 472);
        push_pixel(255, 639, 479);
        // pixels outside the frame are dropped, as is one on an unsampled row
        push_pixel(255, 1023, 0);
        push_pixel(255, 5, 1023);
        push_pixel(128, 0, 0);
        // no marking anywhere
        push_pixel(0, 639, 462);
        push_pixel(255, 639, 479);
        // left only
        push_pixel(255, 300, 462);
        push_pixel(0, 639, 462);
        push_pixel(0, 639, 479);
        wait_idle();

        // tiny frames while the receiver holds off, so frame ends back up
        write_config(4, 24, 128, 16, 3);
        hold_req = hold_req + 1;
        repeat (30) add_frame(1'b0);
        wait_idle();

        // random phases until enough pixels and results have gone through
        while (pixels_sent < ITEM_TARGET || results_seen < RESULT_TARGET) begin
            pick_config();
            repeat ($urandom_range(8, 3))
                add_frame(cfg_width * cfg_height <= 400 && $urandom_range(3, 0) == 0);
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("lane_marking_deviation_scan_unit verification clean");
        else
            $display("lane_marking_deviation_scan_unit verification failed");
        $finish;
    end

endmodule
